// ===== hdl/assert_macros.svh =====
// Assertion macros for the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Antecedent in this cycle implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/cts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_pkg
// Shared widths and scan phase codes for the two-digit charlieplex scanner.
// ----------------------------------------------------------------------------
package cts_pkg;

  localparam int VALUE_W = 8;
  localparam int PIN_W   = 5;
  localparam int PHASE_W = 3;

  // Largest value the display can show
  localparam logic [VALUE_W-1:0] VALUE_MAX = 8'd99;

  // Scan phase codes: idle, then one per common pin
  localparam logic [PHASE_W-1:0] PH_IDLE = 3'd0;
  localparam logic [PHASE_W-1:0] PH_1    = 3'd1;
  localparam logic [PHASE_W-1:0] PH_2    = 3'd2;
  localparam logic [PHASE_W-1:0] PH_3    = 3'd3;
  localparam logic [PHASE_W-1:0] PH_4    = 3'd4;
  localparam logic [PHASE_W-1:0] PH_5    = 3'd5;

  typedef logic [PIN_W-1:0] pins_t;

endpackage

// ===== hdl/charlieplex_two_digit_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// charlieplex_two_digit_scan
// Scanner for a five-pin, two-digit charlieplexed seven-segment display.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready / in_shown_value): one transfer per
//   scan tick, carrying the number to show. Values above 99 show as 99.
//   Result channel (out_valid / out_ready / out_*): one transfer per tick,
//   giving the pin drive enables, the pin levels and the scan phase (1..5).
//   Exactly one common pin is driven low per phase; lit segment pins are
//   driven high; all other pins are undriven and report level 0.
//   Path: a tick taken on the input channel passes the input register, then
//   the result register, before it is presented on the result channel.
//   Throughput: one tick per cycle unless stalled; the only feedback is the
//   3-bit phase counter, updated as a tick moves into the result register.
//   Reset: synchronous, active low; both stages empty and the phase counter
//   cleared so the first tick shows phase 1.
//   Stall: while out_ready is low the result holds; the input register still
//   takes one tick, after which in_ready drops until the result moves on.
// ----------------------------------------------------------------------------
module charlieplex_two_digit_scan (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [cts_pkg::VALUE_W-1:0]  in_shown_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [cts_pkg::PIN_W-1:0]    out_pin_drive_enable,
  output logic [cts_pkg::PIN_W-1:0]    out_pin_level,
  output logic [cts_pkg::PHASE_W-1:0]  out_scan_phase
);

  // Common-cathode segment pattern, bit 0 = A .. bit 6 = G
  function automatic logic [6:0] seg_of(input logic [3:0] digit);
    logic [6:0] segs;
    case (digit)
      4'd0:    segs = 7'h3F;
      4'd1:    segs = 7'h06;
      4'd2:    segs = 7'h5B;
      4'd3:    segs = 7'h4F;
      4'd4:    segs = 7'h66;
      4'd5:    segs = 7'h6D;
      4'd6:    segs = 7'h7D;
      4'd7:    segs = 7'h07;
      4'd8:    segs = 7'h7F;
      4'd9:    segs = 7'h6F;
      default: segs = 7'h00;
    endcase
    return segs;
  endfunction

  logic                          s1_valid_r;
  logic [cts_pkg::VALUE_W-1:0]   s1_value_r;
  logic [cts_pkg::PHASE_W-1:0]   phase_r;
  logic                          out_valid_r;
  cts_pkg::pins_t                drv_r;
  cts_pkg::pins_t                lvl_r;
  logic [cts_pkg::PHASE_W-1:0]   phase_out_r;

  logic                          out_free;
  logic                          advance;
  logic [6:0]                    val_sat;
  logic [14:0]                   tens_prod;
  logic [3:0]                    tens;
  logic [3:0]                    units;
  logic [6:0]                    units_wide;
  logic [6:0]                    t_seg;
  logic [6:0]                    u_seg;
  logic [cts_pkg::PHASE_W-1:0]   phase_nxt;
  cts_pkg::pins_t                common;
  cts_pkg::pins_t                lit;

  // Handshake: result register frees up when empty or being taken
  assign out_free = !out_valid_r || out_ready;
  assign advance  = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || advance;

  // Saturate and split into tens and units (x*205 >> 11 is x/10 below 1029)
  always_comb begin
    val_sat    = (s1_value_r > cts_pkg::VALUE_MAX) ? cts_pkg::VALUE_MAX[6:0]
                                                   : s1_value_r[6:0];
    tens_prod  = 15'(val_sat) * 15'd205;
    tens       = tens_prod[14:11];
    units_wide = val_sat - 7'(tens) * 7'd10;
    units      = units_wide[3:0];
    t_seg      = seg_of(tens);
    u_seg      = seg_of(units);
  end

  // Next phase wraps from 5 (or any stray value) back to 1
  assign phase_nxt = (phase_r >= cts_pkg::PH_5) ? cts_pkg::PH_1
                                                : phase_r + cts_pkg::PH_1;

  // Charlieplex map: one common pin low, lit segment pins high
  always_comb begin
    common = '0;
    lit    = '0;
    case (phase_nxt)
      cts_pkg::PH_1: begin
        common = 5'b00001;
        lit    = {1'b0, u_seg[4], u_seg[0], t_seg[4], 1'b0};
      end
      cts_pkg::PH_2: begin
        common = 5'b00010;
        lit    = {1'b0, u_seg[5], u_seg[1], 1'b0, t_seg[0]};
      end
      cts_pkg::PH_3: begin
        common = 5'b00100;
        lit    = {1'b0, u_seg[6], 1'b0, t_seg[5], t_seg[1]};
      end
      cts_pkg::PH_4: begin
        common = 5'b01000;
        lit    = {1'b0, 1'b0, u_seg[2], t_seg[6], t_seg[2]};
      end
      default: begin
        common = 5'b10000;
        lit    = {1'b0, 1'b0, u_seg[3], 1'b0, t_seg[3]};
      end
    endcase
  end

  // Control registers: stage valids and phase counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= cts_pkg::PH_IDLE;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
      if (advance) begin
        phase_r <= phase_nxt;
      end
    end
  end

  // Payload registers: capture on transfer or advance
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_value_r <= in_shown_value;
    end
    if (advance) begin
      drv_r       <= common | lit;
      lvl_r       <= lit;
      phase_out_r <= phase_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_pin_drive_enable = drv_r;
  assign out_pin_level        = lvl_r;
  assign out_scan_phase       = phase_out_r;

endmodule

// ===== hdl/cts_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_checker
// Port-level checks on the result channel of the charlieplex scanner.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cts_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [cts_pkg::PIN_W-1:0]    out_pin_drive_enable,
  input logic [cts_pkg::PIN_W-1:0]    out_pin_level,
  input logic [cts_pkg::PHASE_W-1:0]  out_scan_phase
);

  // Stalled result holds
  `ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_pin_drive_enable) && $stable(out_pin_level) && $stable(out_scan_phase))

  // Phase within 1..5
  `ASSERT_ALWAYS(a_phase_range, clk, rst_n, !out_valid || (out_scan_phase >= cts_pkg::PH_1 && out_scan_phase <= cts_pkg::PH_5))

  // The single low pin is the common pin of the phase
  `ASSERT_ALWAYS(a_common_pin, clk, rst_n, !out_valid || ((out_pin_drive_enable & ~out_pin_level) == (5'd1 << (out_scan_phase - cts_pkg::PH_1))))

  // Undriven pins report level 0, and pin 5 is never driven high
  `ASSERT_ALWAYS(a_level_driven, clk, rst_n, !out_valid || (((out_pin_level & ~out_pin_drive_enable) == 5'd0) && !out_pin_level[4]))

endmodule

bind charlieplex_two_digit_scan cts_checker u_cts_checker (.*);
